// ===== hdl/rls_pkg.sv =====
// Shared constants for the RGB lightness shading pipeline.
// No dependencies; used by every module of the block except rls_frac_div.
package rls_pkg;

  // Default fractional bits of hue, saturation and lightness.
  localparam int FRAC_BITS = 16;

  // Fixed field layout.
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int SHADE_W    = 18;
  localparam int SHADE_FRAC = 16;

  // Channel sum of white (255 + 255).
  localparam int SUM_W   = CH_W + 1;
  localparam int SUM_MAX = 510;

endpackage

// ===== hdl/rls_frac_div.sv =====
// Pipelined restoring divider: q = (num << F) / den for num <= den.
// One quotient bit per register stage; carries a sideband word alongside.
// Depends on nothing else.
module rls_frac_div #(
  parameter int W  = 9,
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  in_num,
  input  logic [W-1:0]  in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [F:0]    out_q,
  output logic [SW-1:0] out_side
);

  logic [W-1:0]  rem_r   [F+1];
  logic [W-1:0]  den_r   [F+1];
  logic [F:0]    q_r     [F+1];
  logic [SW-1:0] side_r  [F+1];
  logic          valid_r [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_stage
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  den_in;
    logic [F:0]    q_in;
    logic [SW-1:0] side_in;
    logic          valid_in;

    // Select the previous stage, or the input for the first bit
    if (j == 0) begin : g_first
      assign trial    = {1'b0, in_num};
      assign den_in   = in_den;
      assign q_in     = '0;
      assign side_in  = in_side;
      assign valid_in = in_valid;
    end else begin : g_next
      assign trial    = {rem_r[j-1], 1'b0};
      assign den_in   = den_r[j-1];
      assign q_in     = q_r[j-1];
      assign side_in  = side_r[j-1];
      assign valid_in = valid_r[j-1];
    end

    // Trial subtract for one quotient bit
    assign diff = trial - {1'b0, den_in};
    assign ge   = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (en) begin
        valid_r[j] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? diff[W-1:0] : trial[W-1:0];
        den_r[j]  <= den_in;
        q_r[j]    <= q_in | ((F+1)'(ge) << (F - j));
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[F];
  assign out_q     = q_r[F];
  assign out_side  = side_r[F];

endmodule

// ===== hdl/rls_to_hsl.sv =====
// Front half: unpack RGB, find max/min, derive lightness, saturation
// and hue, add the shade offset. Uses rls_pkg and rls_frac_div.
module rls_to_hsl #(
  parameter int F = rls_pkg::FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [rls_pkg::PIX_W-1:0]  in_pixel,
  input  logic [rls_pkg::SHADE_W-1:0] in_shade,
  output logic                       out_valid,
  output logic [F:0]                 out_h,
  output logic [F:0]                 out_s,
  output logic [F:0]                 out_l
);

  localparam int CW    = rls_pkg::CH_W;
  localparam int SMW   = rls_pkg::SUM_W;
  localparam int SHX_W = (F >= rls_pkg::SHADE_FRAC) ?
                         rls_pkg::SHADE_W + F - rls_pkg::SHADE_FRAC : rls_pkg::SHADE_W;
  localparam int LS_W  = ((SHX_W > F + 2) ? SHX_W : F + 2) + 1;
  localparam int H6_W  = F + 3;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // Reciprocal constants: lightness = sum * 2^F / 510, hue = h6 / 6
  localparam int LE = 18;
  localparam int HE = F + 6;
  localparam longint L_REC_I = ((longint'(1) << (F + LE)) + longint'(rls_pkg::SUM_MAX) - 1) /
                               longint'(rls_pkg::SUM_MAX);
  localparam longint H_REC_I = ((longint'(1) << HE) + 5) / 6;
  localparam logic [F+9:0] L_REC = (F+10)'(L_REC_I);
  localparam logic [F+3:0] H_REC = (F+4)'(H_REC_I);

  // Unpack and sort channels
  logic [CW-1:0] r, g, b, mx_rg, mn_rg, mx, mn, hnum;
  logic [2:0]    base;
  logic          neg;
  logic [SMW-1:0] sum, sden;
  logic signed [SHX_W-1:0] shade_x;

  assign r     = in_pixel[3*CW-1:2*CW];
  assign g     = in_pixel[2*CW-1:CW];
  assign b     = in_pixel[CW-1:0];
  assign mx_rg = (r > g) ? r : g;
  assign mn_rg = (r < g) ? r : g;
  assign mx    = (mx_rg > b) ? mx_rg : b;
  assign mn    = (mn_rg < b) ? mn_rg : b;
  assign sum   = {1'b0, mx} + {1'b0, mn};
  assign sden  = (sum <= SMW'(255)) ? sum : SMW'(rls_pkg::SUM_MAX) - sum;

  // Hexcone sextant base, direction and numerator channel
  always_comb begin
    if (r == mx) begin
      if (g == mn) begin
        base = 3'd5; neg = 1'b0; hnum = mx - b;
      end else begin
        base = 3'd1; neg = 1'b1; hnum = mx - g;
      end
    end else if (g == mx) begin
      if (b == mn) begin
        base = 3'd1; neg = 1'b0; hnum = mx - r;
      end else begin
        base = 3'd3; neg = 1'b1; hnum = mx - b;
      end
    end else begin
      if (r == mn) begin
        base = 3'd3; neg = 1'b0; hnum = mx - g;
      end else begin
        base = 3'd5; neg = 1'b1; hnum = mx - r;
      end
    end
  end

  // Rescale the offset to F fractional bits (floor on right shift)
  if (F >= rls_pkg::SHADE_FRAC) begin : g_shl
    assign shade_x = SHX_W'($signed(in_shade)) <<< (F - rls_pkg::SHADE_FRAC);
  end else begin : g_shr
    assign shade_x = $signed(in_shade) >>> (rls_pkg::SHADE_FRAC - F);
  end

  // Input register stage
  logic                    v0_r;
  logic [CW-1:0]           hnum_r, d_r;
  logic [SMW-1:0]          sum_r, sden_r;
  logic [2:0]              base_r;
  logic                    neg_r, grey_r;
  logic signed [SHX_W-1:0] shade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hnum_r  <= hnum;
      d_r     <= mx - mn;
      sum_r   <= sum;
      sden_r  <= sden;
      base_r  <= base;
      neg_r   <= neg;
      grey_r  <= (mx == mn);
      shade_r <= shade_x;
    end
  end

  // Lightness by reciprocal multiply, truncated
  logic [SMW+F+9:0] l_prod;
  logic [F:0]       l_fix;

  assign l_prod = {{(F+10){1'b0}}, sum_r} * {{SMW{1'b0}}, L_REC};
  assign l_fix  = l_prod[F+LE:LE];

  // Two dividers in parallel: saturation and hue fraction; lightness rides along
  localparam int SSW = 1 + (F + 1) + SHX_W;
  logic             sv, hv;
  logic [F:0]       lq, sq, hq;
  logic [SHX_W-1:0] l_side;
  logic             s_side;
  logic [SSW-1:0]   s_out;
  logic [3:0]       h_side;

  rls_frac_div #(.W(SMW), .F(F), .SW(SSW)) u_div_s (
    .clk, .rst_n, .en,
    .in_valid (v0_r),
    .in_num   ({1'b0, d_r}),
    .in_den   (grey_r ? SMW'(1) : sden_r),
    .in_side  ({grey_r, l_fix, shade_r}),
    .out_valid(sv),
    .out_q    (sq),
    .out_side (s_out)
  );

  assign s_side = s_out[SSW-1];
  assign lq     = s_out[SSW-2:SHX_W];
  assign l_side = s_out[SHX_W-1:0];

  rls_frac_div #(.W(SMW), .F(F), .SW(4)) u_div_h (
    .clk, .rst_n, .en,
    .in_valid (v0_r),
    .in_num   ({1'b0, hnum_r}),
    .in_den   (grey_r ? SMW'(1) : {1'b0, d_r}),
    .in_side  ({base_r, neg_r}),
    .out_valid(hv),
    .out_q    (hq),
    .out_side (h_side)
  );

  // Assemble six-sextant hue, shade and clamp lightness
  logic [H6_W-1:0]        h6_base, h6;
  logic signed [LS_W-1:0] lsum;
  logic [F:0]             lc;

  assign h6_base = H6_W'(h_side[3:1]) << F;
  assign h6      = s_side ? '0 :
                   (h_side[0] ? h6_base - H6_W'(hq) : h6_base + H6_W'(hq));
  assign lsum    = $signed({{(LS_W-F-1){1'b0}}, lq}) + LS_W'($signed(l_side));

  always_comb begin
    if (lsum < 0) begin
      lc = '0;
    end else if (lsum > $signed({{(LS_W-F-1){1'b0}}, ONE})) begin
      lc = ONE;
    end else begin
      lc = lsum[F:0];
    end
  end

  logic            va_r;
  logic [H6_W-1:0] h6_r;
  logic [F:0]      la_r, sa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= sv & hv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h6_r <= h6;
      la_r <= lc;
      sa_r <= s_side ? '0 : sq;
    end
  end

  // Hue = six-sextant value / 6, by reciprocal multiply
  logic [2*F+6:0] h_prod;
  logic           vo_r;
  logic [F:0]     ho_r, lo_r, so_r;

  assign h_prod = {{(F+4){1'b0}}, h6_r} * {{(F+3){1'b0}}, H_REC};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ho_r <= h_prod[2*F+6:HE];
      lo_r <= la_r;
      so_r <= sa_r;
    end
  end

  assign out_valid = vo_r;
  assign out_h     = ho_r;
  assign out_l     = lo_r;
  assign out_s     = so_r;

endmodule

// ===== hdl/rls_to_rgb.sv =====
// Back half: HSL to RGB with products and one divider, then channel
// scaling and packing. Uses rls_pkg and rls_frac_div.
module rls_to_rgb #(
  parameter int F = rls_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [F:0]                in_h,
  input  logic [F:0]                in_s,
  input  logic [F:0]                in_l,
  output logic                      out_valid,
  output logic [rls_pkg::PIX_W-1:0] out_pixel
);

  localparam int CW  = rls_pkg::CH_W;
  localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};

  // Scale a unit value to an 8-bit channel
  function automatic logic [CW-1:0] to_ch(input logic [F:0] x);
    logic [F+CW:0] p;
    logic [F+CW:0] c;
    p = ({{CW{1'b0}}, x} << CW) - {{CW{1'b0}}, x};
    c = p >> F;
    to_ch = (c > (F+CW+1)'(255)) ? CW'(255) : c[CW-1:0];
  endfunction

  // Stage B: L * S
  logic           vb_r;
  logic [2*F+1:0] ls_r;
  logic [F:0]     lb_r, sb_r, hb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls_r <= in_l * in_s;
      lb_r <= in_l;
      sb_r <= in_s;
      hb_r <= in_h;
    end
  end

  // Stage C: value = max channel level, clamped
  logic [F+2:0] lsf, vsum;
  logic [F:0]   vc;

  assign lsf  = (F+3)'(ls_r >> F);
  assign vsum = (lb_r <= HALF) ? (F+3)'(lb_r) + lsf
                               : (F+3)'(lb_r) + (F+3)'(sb_r) - lsf;
  assign vc   = (vsum > (F+3)'(ONE)) ? ONE : vsum[F:0];

  logic       vc_r;
  logic [F:0] v_c_r, l_c_r, h_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_c_r <= vc;
      l_c_r <= lb_r;
      h_c_r <= hb_r;
    end
  end

  // Stage D: min level, divider operands, sextant split of hue
  logic signed [F+2:0] m2;
  logic [F:0]          mc;
  logic [F+2:0]        h6;

  assign m2 = $signed({1'b0, l_c_r, 1'b0}) - $signed({2'b00, v_c_r});
  assign mc = (m2 < 0) ? '0 : ((m2 > $signed((F+3)'(ONE))) ? ONE : m2[F:0]);
  assign h6 = ({2'b00, h_c_r} << 2) + ({2'b00, h_c_r} << 1);

  logic       vd_r;
  logic [F:0] num_d_r, den_d_r, v_d_r, m_d_r, l_d_r;
  logic [2:0] sext_d_r;
  logic [F-1:0] fr_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_d_r  <= (mc < v_c_r) ? v_c_r - mc : '0;
      den_d_r  <= (v_c_r == '0) ? (F+1)'(1) : v_c_r;
      v_d_r    <= v_c_r;
      m_d_r    <= mc;
      l_d_r    <= l_c_r;
      sext_d_r <= h6[F+2:F];
      fr_d_r   <= h6[F-1:0];
    end
  end

  // Chroma ratio (v - m) / v
  localparam int SDW = 3 * (F + 1) + 3 + F;
  logic           svv;
  logic [F:0]     svq;
  logic [SDW-1:0] sd;

  rls_frac_div #(.W(F+1), .F(F), .SW(SDW)) u_div_sv (
    .clk, .rst_n, .en,
    .in_valid (vd_r),
    .in_num   (num_d_r),
    .in_den   (den_d_r),
    .in_side  ({v_d_r, m_d_r, l_d_r, sext_d_r, fr_d_r}),
    .out_valid(svv),
    .out_q    (svq),
    .out_side (sd)
  );

  // Stage E: v * sv
  logic           ve_r;
  logic [2*F+1:0] vs_r;
  logic [SDW-1:0] se_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= svv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vs_r <= sd[SDW-1:SDW-F-1] * svq;
      se_r <= sd;
    end
  end

  // Stage F: times hue fraction
  logic [F:0]     vsa;
  logic           vf_r;
  logic [2*F:0]   vsf_p_r;
  logic [SDW-1:0] sf_r;

  assign vsa = vs_r[2*F:F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vsf_p_r <= vsa * se_r[F-1:0];
      sf_r    <= se_r;
    end
  end

  // Stage G: intermediate levels and sextant select
  logic [F:0]          vg, mg, lg, vsf, mid1, mid2;
  logic [2:0]          sg;
  logic [F+1:0]        m_plus;
  logic signed [F+1:0] v_minus;
  logic [F:0]          ro, go, bo;

  assign vg      = sf_r[SDW-1:SDW-F-1];
  assign mg      = sf_r[SDW-F-2:SDW-2*F-2];
  assign lg      = sf_r[SDW-2*F-3:SDW-3*F-3];
  assign sg      = sf_r[F+2:F];
  assign vsf     = vsf_p_r[2*F:F];
  assign m_plus  = {1'b0, mg} + {1'b0, vsf};
  assign v_minus = $signed({1'b0, vg}) - $signed({1'b0, vsf});
  assign mid1    = (m_plus > (F+2)'(ONE)) ? ONE : m_plus[F:0];
  assign mid2    = (v_minus < 0) ? '0 : v_minus[F:0];

  always_comb begin
    if (vg == '0) begin
      ro = lg; go = lg; bo = lg;
    end else begin
      case (sg)
        3'd1:    begin ro = mid2; go = vg;   bo = mg;   end
        3'd2:    begin ro = mg;   go = vg;   bo = mid1; end
        3'd3:    begin ro = mg;   go = mid2; bo = vg;   end
        3'd4:    begin ro = mid1; go = mg;   bo = vg;   end
        3'd5:    begin ro = vg;   go = mg;   bo = mid2; end
        // Sextant zero, and hue of one wrapping back to red
        default: begin ro = vg;   go = mid1; bo = mg;   end
      endcase
    end
  end

  logic       vg_r;
  logic [F:0] ro_r, go_r, bo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ro_r <= ro;
      go_r <= go;
      bo_r <= bo;
    end
  end

  // Stage H: scale to 8-bit channels and pack
  logic                      vh_r;
  logic [rls_pkg::PIX_W-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (en) begin
      vh_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= {to_ch(ro_r), to_ch(go_r), to_ch(bo_r)};
    end
  end

  assign out_valid = vh_r;
  assign out_pixel = pix_r;

endmodule

// ===== hdl/rgb_lightness_shade.sv =====
// RGB lightness shading: one pixel per clock through a pipeline while in_stall is low.
// Depends on rls_pkg, rls_to_hsl, rls_to_rgb (and through them rls_frac_div).
//
// Each transaction carries one packed RGB pixel and a signed lightness offset
// (16 fractional bits); one shaded pixel comes out per transaction, in order.
// The block takes a new pixel every cycle while in_stall is low. The two
// bit-serial divider pipelines (saturation and hue fraction side by side,
// then chroma ratio), each FRAC_BITS+1 stages deep, make up most of the
// pipeline; lightness and hue by six use reciprocal multiplies. A two-entry
// output register and skid stage lets the pipeline keep advancing after the
// output stalls until a pixel parks in the skid entry; in_stall rises only
// when the skid entry is full, and the whole pipeline then holds.
module rgb_lightness_shade #(
  parameter int FRAC_BITS = rls_pkg::FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rls_pkg::PIX_W-1:0]   in_pixel_in,
  input  logic [rls_pkg::SHADE_W-1:0] in_shade_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rls_pkg::PIX_W-1:0]   out_pixel_out
);

  localparam int F = FRAC_BITS;

  logic                      en;
  logic                      hsl_valid, pipe_valid;
  logic [F:0]                h, s, l;
  logic [rls_pkg::PIX_W-1:0] pipe_pixel;

  logic                      out_valid_r, skid_valid_r;
  logic [rls_pkg::PIX_W-1:0] out_pixel_r, skid_pixel_r;

  // Advance the pipeline unless the skid entry holds a transaction
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  rls_to_hsl #(.F(F)) u_to_hsl (
    .clk, .rst_n, .en,
    .in_valid (in_valid),
    .in_pixel (in_pixel_in),
    .in_shade (in_shade_amount),
    .out_valid(hsl_valid),
    .out_h    (h),
    .out_s    (s),
    .out_l    (l)
  );

  rls_to_rgb #(.F(F)) u_to_rgb (
    .clk, .rst_n, .en,
    .in_valid (hsl_valid),
    .in_h     (h),
    .in_s     (s),
    .in_l     (l),
    .out_valid(pipe_valid),
    .out_pixel(pipe_pixel)
  );

  // Output register with skid: drain skid first, park pipeline data on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= pipe_valid;
      end
    end else if (en && pipe_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_pixel_r <= skid_valid_r ? skid_pixel_r : pipe_pixel;
    end else if (en && pipe_valid) begin
      skid_pixel_r <= pipe_pixel;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

endmodule

// ===== tb/rgb_lightness_shade_tb.sv =====
// Self-checking testbench for rgb_lightness_shade: HSL lightness shading of RGB pixels.
// Depends on rls_pkg and the block; holds its own fixed-point predictor of the pipeline.
module rgb_lightness_shade_tb;

  localparam int F = rls_pkg::FRAC_BITS;
  localparam int PW = rls_pkg::PIX_W;
  localparam int SW = rls_pkg::SHADE_W;
  localparam longint UNIT = longint'(1) << F;
  localparam int LATENCY = 2 * F + 13;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PW-1:0] in_pixel_in = '0;
  logic [SW-1:0] in_shade_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PW-1:0] out_pixel_out;

  logic [PW-1:0] shaded_q[$];
  int errors = 0;
  longint cycles = 0;
  int gap_max = 3;
  int hold_off = 0;
  bit hold_kick = 1'b0;
  bit hold_seen = 1'b0;
  bit stall_random = 1'b1;

  rgb_lightness_shade u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_in(in_pixel_in), .in_shade_amount(in_shade_amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_out(out_pixel_out)
  );

  always #2 clk = ~clk;

  // Count cycles and abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint unit_clamp(longint x);
    if (x < 0) return 0;
    if (x > UNIT) return UNIT;
    return x;
  endfunction

  function automatic logic [7:0] channel_of(longint x);
    longint c;
    c = (unit_clamp(x) * 255) >>> F;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  // Predict the shaded pixel for one transaction
  function automatic logic [PW-1:0] shade_pixel(logic [PW-1:0] pix,
                                                logic [SW-1:0] amt);
    longint r, g, b, mx, mn, sum, d, lt, sat, hue, h6, rd, gd, bd, off;
    longint v, ro, go, bo, m, sv, sext, fr, vsf, mid1, mid2;
    r = pix[23:16]; g = pix[15:8]; b = pix[7:0];
    mx = (r > g) ? r : g; mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g; mn = (mn < b) ? mn : b;
    sum = mx + mn; d = mx - mn;
    lt = (sum << F) / rls_pkg::SUM_MAX;
    sat = 0; hue = 0;
    if (sum > 0 && d > 0) begin
      rd = ((mx - r) << F) / d;
      gd = ((mx - g) << F) / d;
      bd = ((mx - b) << F) / d;
      sat = (d << F) / ((sum <= 255) ? sum : rls_pkg::SUM_MAX - sum);
      if (r == mx) h6 = (g == mn) ? 5 * UNIT + bd : UNIT - gd;
      else if (g == mx) h6 = (b == mn) ? UNIT + rd : 3 * UNIT - bd;
      else h6 = (r == mn) ? 3 * UNIT + gd : 5 * UNIT - rd;
      hue = unit_clamp(h6 / 6);
    end
    off = longint'($signed(amt));
    if (F >= rls_pkg::SHADE_FRAC) off = off <<< (F - rls_pkg::SHADE_FRAC);
    else off = off >>> (rls_pkg::SHADE_FRAC - F);
    lt = unit_clamp(lt + off);
    sat = unit_clamp(sat);
    if (lt <= UNIT / 2) v = (lt * (UNIT + sat)) >>> F;
    else v = lt + sat - ((lt * sat) >>> F);
    v = unit_clamp(v);
    ro = lt; go = lt; bo = lt;
    if (v > 0) begin
      m = unit_clamp(2 * lt - v);
      sv = (m < v) ? ((v - m) << F) / v : 0;
      h6 = hue * 6;
      sext = h6 >>> F;
      fr = h6 & (UNIT - 1);
      vsf = (((v * sv) >>> F) * fr) >>> F;
      mid1 = unit_clamp(m + vsf);
      mid2 = unit_clamp(v - vsf);
      // wrap a full-turn hue back to red
      if (sext >= 6) sext = 0;
      case (sext)
        0: begin ro = v; go = mid1; bo = m; end
        1: begin ro = mid2; go = v; bo = m; end
        2: begin ro = m; go = v; bo = mid1; end
        3: begin ro = m; go = mid2; bo = v; end
        4: begin ro = mid1; go = m; bo = v; end
        default: begin ro = v; go = m; bo = mid2; end
      endcase
    end
    return {channel_of(ro), channel_of(go), channel_of(bo)};
  endfunction

  // Receiver stall: random pattern, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_off <= 4 * LATENCY;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (stall_random) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    logic [PW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (shaded_q.size() == 0) begin
        $display("%0t: unexpected pixel_out actual %06h", $time, out_pixel_out);
        errors++;
      end else begin
        want = shaded_q.pop_front();
        if (out_pixel_out !== want) begin
          $display("%0t: pixel_out expected %06h actual %06h", $time, want, out_pixel_out);
          errors++;
        end
      end
    end
  end

  // Send one transaction and hold it until accepted
  task automatic send_pixel(logic [PW-1:0] pix, logic [SW-1:0] amt);
    in_valid <= 1'b1;
    in_pixel_in <= pix;
    in_shade_amount <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shaded_q.push_back(shade_pixel(pix, amt));
  endtask

  // Drop valid for a random gap, sometimes none
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, gap_max) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [SW-1:0] random_shade();
    case ($urandom_range(0, 4))
      0: return SW'($urandom);
      1: return SW'(-$signed({1'b0, 16'($urandom)}));
      default: return SW'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  task automatic test_extremes();
    logic [PW-1:0] pix[12];
    logic [SW-1:0] amt[6];
    pix = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
            24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
            24'h123456, 24'h010000};
    amt = '{18'h00000, 18'h10000, 18'h30000, 18'h20000, 18'h1FFFF, 18'h08000};
    for (int i = 0; i < 12; i++) send_pixel(pix[i], amt[i % 6]);
    // out-of-range and tiny negative offsets on colored pixels
    send_pixel(24'hFF8040, 18'h1FFFF);
    send_pixel(24'h40FF80, 18'h20000);
    send_pixel(24'h8040FF, 18'h3FFFF);
  endtask

  task automatic test_random(int count);
    logic [PW-1:0] pix;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: pix = {3{8'($urandom)}};
        1: pix = {8'hFF, 8'($urandom), 8'h00};
        default: pix = PW'($urandom);
      endcase
      send_pixel(pix, random_shade());
      idle_gap();
    end
  endtask

  // Hold the output off long enough that the pipeline fills and stalls its input
  task automatic test_backpressure();
    hold_kick <= ~hold_kick;
    for (int i = 0; i < 3 * LATENCY; i++) send_pixel(PW'($urandom), random_shade());
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (shaded_q.size() != 0 && n < 50 * LATENCY + 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random(750);
    test_backpressure();
    stall_random <= 1'b0;
    gap_max <= 1;
    test_random(400);
    stall_random <= 1'b1;
    gap_max <= 20;
    test_random(250);
    drain();
    if (errors == 0 && shaded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
